@@ rtl/wsdefr_pkg.sv @@
// Shared types, constants and helpers for the WebSocket frame deframer.
// Depends on nothing; every rtl module refers to it by scoped names.
`default_nettype none

package wsdefr_pkg;

  localparam int unsigned LENGTH_BITS = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);
  localparam int unsigned QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  localparam logic [3:0] OP_CONT  = 4'h0;
  localparam logic [3:0] OP_TEXT  = 4'h1;
  localparam logic [3:0] OP_CLOSE = 4'h8;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;

  localparam logic [3:0] EXT_BYTES_16 = 4'd2;
  localparam logic [3:0] EXT_BYTES_64 = 4'd8;
  localparam logic [3:0] MASK_BYTES   = 4'd4;

  localparam logic [1:0] KIND_DATA  = 2'd0;
  localparam logic [1:0] KIND_CLOSE = 2'd1;
  localparam logic [1:0] KIND_OTHER = 2'd2;

  typedef enum logic [4:0] {
    PH_B0   = 5'b00001,
    PH_B1   = 5'b00010,
    PH_EXT  = 5'b00100,
    PH_MASK = 5'b01000,
    PH_DATA = 5'b10000
  } phase_e;

  typedef struct packed {
    logic [7:0] payload;
    logic [1:0] kind;
    logic       first;
    logic       last;
    logic       empty;
  } word_t;

  typedef struct packed {
    logic  valid;
    word_t word;
  } push_t;

  function automatic logic [1:0] kind_of(input logic [3:0] op);
    logic [1:0] k;
    k = KIND_OTHER;
    if (op == OP_CONT || op == OP_TEXT) k = KIND_DATA;
    else if (op == OP_CLOSE) k = KIND_CLOSE;
    return k;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wsdefr_parser.sv @@
// Front part: header parser that classifies each stream byte and pushes words.
// Depends on wsdefr_pkg.
`default_nettype none

module wsdefr_parser (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic [7:0]          byte_i,
  output wsdefr_pkg::push_t        push_o
);

  wsdefr_pkg::phase_e                       phase_q, phase_d;
  logic [3:0]                               opcode_q, opcode_d;
  logic                                     mask_q, mask_d;
  logic                                     long_q, long_d;
  logic [3:0]                               hcnt_q, hcnt_d;
  logic [wsdefr_pkg::LENGTH_BITS-1:0]       rem_q, rem_d;
  logic                                     first_q, first_d;

  logic [6:0]                               code;
  logic [3:0]                               hcnt_inc;
  logic [3:0]                               ext_total;
  logic [wsdefr_pkg::LENGTH_BITS-1:0]       rem_shift;
  logic [wsdefr_pkg::LENGTH_BITS-1:0]       rem_dec;
  logic [wsdefr_pkg::LENGTH_BITS-1:0]       len_val;
  logic                                     len_done;
  logic                                     hdr_done;
  logic                                     emit_empty;
  logic                                     emit_data;

  assign code      = byte_i[6:0];
  assign hcnt_inc  = hcnt_q + 4'd1;
  assign ext_total = long_q ? wsdefr_pkg::EXT_BYTES_64 : wsdefr_pkg::EXT_BYTES_16;
  assign rem_shift = {rem_q[wsdefr_pkg::LENGTH_BITS-9:0], byte_i};
  assign rem_dec   = rem_q - {{(wsdefr_pkg::LENGTH_BITS-1){1'b0}}, 1'b1};

  always_comb begin
    phase_d    = phase_q;
    opcode_d   = opcode_q;
    mask_d     = mask_q;
    long_d     = long_q;
    hcnt_d     = hcnt_q;
    rem_d      = rem_q;
    first_d    = first_q;
    len_val    = rem_q;
    len_done   = 1'b0;
    hdr_done   = 1'b0;
    emit_empty = 1'b0;
    emit_data  = 1'b0;

    if (accept_i) begin
      case (phase_q)
        wsdefr_pkg::PH_B0: begin
          opcode_d = byte_i[3:0];
          phase_d  = wsdefr_pkg::PH_B1;
        end
        wsdefr_pkg::PH_B1: begin
          mask_d = byte_i[7];
          hcnt_d = 4'd0;
          if (code == wsdefr_pkg::LEN_CODE_16 || code == wsdefr_pkg::LEN_CODE_64) begin
            long_d  = (code == wsdefr_pkg::LEN_CODE_64);
            rem_d   = '0;
            phase_d = wsdefr_pkg::PH_EXT;
          end else begin
            len_val  = {{(wsdefr_pkg::LENGTH_BITS-7){1'b0}}, code};
            rem_d    = len_val;
            len_done = 1'b1;
          end
        end
        wsdefr_pkg::PH_EXT: begin
          rem_d   = rem_shift;
          len_val = rem_shift;
          hcnt_d  = hcnt_inc;
          if (hcnt_inc >= ext_total) len_done = 1'b1;
        end
        wsdefr_pkg::PH_MASK: begin
          hcnt_d = hcnt_inc;
          if (hcnt_inc >= wsdefr_pkg::MASK_BYTES) hdr_done = 1'b1;
        end
        wsdefr_pkg::PH_DATA: begin
          rem_d     = rem_dec;
          emit_data = 1'b1;
          first_d   = 1'b0;
          if (rem_dec == '0) phase_d = wsdefr_pkg::PH_B0;
        end
        default: begin
          phase_d = wsdefr_pkg::PH_B0;
        end
      endcase

      if (len_done) begin
        if (mask_d) begin
          phase_d = wsdefr_pkg::PH_MASK;
          hcnt_d  = 4'd0;
        end else begin
          hdr_done = 1'b1;
        end
      end

      if (hdr_done) begin
        if (len_val == '0) begin
          emit_empty = 1'b1;
          first_d    = 1'b0;
          phase_d    = wsdefr_pkg::PH_B0;
        end else begin
          first_d = 1'b1;
          phase_d = wsdefr_pkg::PH_DATA;
        end
      end
    end
  end

  always_comb begin
    push_o.valid      = emit_data | emit_empty;
    push_o.word.kind  = wsdefr_pkg::kind_of(opcode_q);
    push_o.word.empty = emit_empty;
    if (emit_empty) begin
      push_o.word.payload = 8'h00;
      push_o.word.first   = 1'b1;
      push_o.word.last    = 1'b1;
    end else begin
      push_o.word.payload = byte_i;
      push_o.word.first   = first_q;
      push_o.word.last    = (rem_dec == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsdefr_pkg::PH_B0;
      opcode_q <= 4'h0;
      mask_q   <= 1'b0;
      long_q   <= 1'b0;
      hcnt_q   <= 4'd0;
      rem_q    <= '0;
      first_q  <= 1'b1;
    end else begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      mask_q   <= mask_d;
      long_q   <= long_d;
      hcnt_q   <= hcnt_d;
      rem_q    <= rem_d;
      first_q  <= first_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsdefr_queue.sv @@
// Short word queue between the parser and the output stage.
// Depends on wsdefr_pkg.
`default_nettype none

module wsdefr_queue (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wsdefr_pkg::push_t   push_i,
  input  wire logic                pop_i,
  output wsdefr_pkg::word_t        head_o,
  output logic                     not_empty_o,
  output logic                     full_o
);

  wsdefr_pkg::word_t                  mem_q [wsdefr_pkg::QUEUE_DEPTH];
  logic [wsdefr_pkg::QUEUE_AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [wsdefr_pkg::QUEUE_CW-1:0]    count_q;
  logic                               do_push, do_pop;

  assign full_o      = (count_q == wsdefr_pkg::QUEUE_CW'(wsdefr_pkg::QUEUE_DEPTH));
  assign not_empty_o = (count_q != '0);
  assign head_o      = mem_q[rd_ptr_q];
  assign do_push     = push_i.valid && !full_o;
  assign do_pop      = pop_i && not_empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= push_i.word;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == wsdefr_pkg::QUEUE_AW'(wsdefr_pkg::QUEUE_DEPTH - 1))
                    ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == wsdefr_pkg::QUEUE_AW'(wsdefr_pkg::QUEUE_DEPTH - 1))
                    ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) count_q <= count_q + wsdefr_pkg::QUEUE_CW'(1);
      else if (do_pop && !do_push) count_q <= count_q - wsdefr_pkg::QUEUE_CW'(1);
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsdefr_outreg.sv @@
// Back part: output register that drains the queue onto the result channel.
// Depends on wsdefr_pkg.
`default_nettype none

module wsdefr_outreg (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire wsdefr_pkg::word_t   head_i,
  input  wire logic                not_empty_i,
  output logic                     pop_o,
  input  wire logic                ready_i,
  output logic                     valid_o,
  output wsdefr_pkg::word_t        word_o
);

  logic              valid_q;
  wsdefr_pkg::word_t word_q;

  assign pop_o   = not_empty_i && (!valid_q || ready_i);
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_ff @(posedge clk_i) begin
    if (pop_o) word_q <= head_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (pop_o) begin
      valid_q <= 1'b1;
    end else if (ready_i) begin
      valid_q <= 1'b0;
    end
  end

endmodule

`default_nettype wire

@@ rtl/websocket_frame_deframer_unit.sv @@
// Top level of the WebSocket frame deframer: parser, word queue, output register.
// Depends on wsdefr_pkg, wsdefr_parser, wsdefr_queue and wsdefr_outreg.
//
//   channel  handshake                  payload
//   input    in_valid_i / in_ready_o    stream_byte_i
//   output   out_valid_o / out_ready_i  payload_byte_o, frame_kind_o, first_of_frame_o,
//                                       last_of_frame_o, empty_frame_o
//
// One stream byte is taken per cycle while in_ready_o is high.
// The parser updates its header state and payload count in the cycle of acceptance.
// A two-word queue and the output register absorb output stalls; in_ready_o drops
// only while the queue is full.
// Reset returns the parser to the first header byte and empties queue and output.
`default_nettype none

module websocket_frame_deframer_unit (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire logic [7:0] stream_byte_i,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  output logic [7:0]      payload_byte_o,
  output logic [1:0]      frame_kind_o,
  output logic            first_of_frame_o,
  output logic            last_of_frame_o,
  output logic            empty_frame_o
);

  wsdefr_pkg::push_t push;
  wsdefr_pkg::word_t head;
  wsdefr_pkg::word_t out_word;
  logic              q_full, q_not_empty, q_pop, accept;

  assign in_ready_o = !q_full;
  assign accept     = in_valid_i && in_ready_o;

  wsdefr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .byte_i   (stream_byte_i),
    .push_o   (push)
  );

  wsdefr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .pop_i       (q_pop),
    .head_o      (head),
    .not_empty_o (q_not_empty),
    .full_o      (q_full)
  );

  wsdefr_outreg u_outreg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .head_i      (head),
    .not_empty_i (q_not_empty),
    .pop_o       (q_pop),
    .ready_i     (out_ready_i),
    .valid_o     (out_valid_o),
    .word_o      (out_word)
  );

  assign payload_byte_o   = out_word.payload;
  assign frame_kind_o     = out_word.kind;
  assign first_of_frame_o = out_word.first;
  assign last_of_frame_o  = out_word.last;
  assign empty_frame_o    = out_word.empty;

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench for websocket_frame_deframer_unit: directed frames with tabled words, then
// random frames under four idling mixes, checked against a byte-level frame parser.
// Depends on wsdefr_pkg and the deframer RTL.
`timescale 1ns / 100ps

module tb_top;
  import wsdefr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int PHASE_BYTES = 250;
  localparam int DIR_ROWS    = 23;

  typedef struct {
    logic [7:0] b;
    logic       typed;
    word_t      want;
  } row_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] stream_byte = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] payload_byte;
  logic [1:0] frame_kind;
  logic       first_of_frame;
  logic       last_of_frame;
  logic       empty_frame;

  int unsigned src_idle_pct = 0;
  int unsigned sink_stall_pct = 0;
  int unsigned err_count = 0;
  int unsigned cycles = 0;
  int unsigned bytes_sent = 0;

  word_t expected_words[$];

  // parser state
  phase_e                 ph = PH_B0;
  logic [3:0]             op_r = 4'h0;
  logic                   masked_r = 1'b0;
  logic [3:0]             hdr_cnt = 4'h0;
  logic [3:0]             ext_need = 4'h0;
  logic [LENGTH_BITS-1:0] remaining = '0;
  logic                   first_pend = 1'b1;

  row_t dir_rows [DIR_ROWS] = '{
    '{8'h81, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, KIND_DATA, 1'b1, 1'b1, 1'b1}},
    '{8'h88, 1'b0, '0},
    '{8'h01, 1'b0, '0},
    '{8'hFF, 1'b1, '{8'hFF, KIND_CLOSE, 1'b1, 1'b1, 1'b0}},
    '{8'hF0, 1'b0, '0},
    '{8'h82, 1'b0, '0},
    '{8'hA5, 1'b0, '0},
    '{8'h5A, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'hFF, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, KIND_DATA, 1'b1, 1'b0, 1'b0}},
    '{8'h80, 1'b1, '{8'h80, KIND_DATA, 1'b0, 1'b1, 1'b0}},
    '{8'h0F, 1'b0, '0},
    '{8'h7F, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b0, '0},
    '{8'h00, 1'b1, '{8'h00, KIND_OTHER, 1'b1, 1'b1, 1'b1}}
  };

  websocket_frame_deframer_unit dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .stream_byte_i    (stream_byte),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .payload_byte_o   (payload_byte),
    .frame_kind_o     (frame_kind),
    .first_of_frame_o (first_of_frame),
    .last_of_frame_o  (last_of_frame),
    .empty_frame_o    (empty_frame)
  );

  always #2 clk = ~clk;

  task automatic emit_word(input logic [7:0] data, input logic last, input logic empty,
                           output logic got, output word_t w);
    w.payload = data;
    case (op_r)
      OP_CONT, OP_TEXT: w.kind = KIND_DATA;
      OP_CLOSE:         w.kind = KIND_CLOSE;
      default:          w.kind = KIND_OTHER;
    endcase
    w.first = first_pend;
    w.last = last;
    w.empty = empty;
    first_pend = 1'b0;
    got = 1'b1;
  endtask

  task automatic end_of_header(output logic got, output word_t w);
    first_pend = 1'b1;
    if (remaining == '0) begin
      ph = PH_B0;
      emit_word(8'h00, 1'b1, 1'b1, got, w);
    end else begin
      ph = PH_DATA;
    end
  endtask

  task automatic end_of_length(output logic got, output word_t w);
    if (masked_r) begin
      ph = PH_MASK;
      hdr_cnt = 4'h0;
    end else begin
      end_of_header(got, w);
    end
  endtask

  task automatic deframe_byte(input logic [7:0] b, output logic got, output word_t w);
    logic [6:0] code;
    got = 1'b0;
    w = '0;
    code = b[6:0];
    case (ph)
      PH_B0: begin
        op_r = b[3:0];
        ph = PH_B1;
      end
      PH_B1: begin
        masked_r = b[7];
        hdr_cnt = 4'h0;
        remaining = '0;
        if (code == LEN_CODE_16 || code == LEN_CODE_64) begin
          ext_need = (code == LEN_CODE_16) ? EXT_BYTES_16 : EXT_BYTES_64;
          ph = PH_EXT;
        end else begin
          remaining[6:0] = code;
          end_of_length(got, w);
        end
      end
      PH_EXT: begin
        remaining = (remaining << 8) | b;
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= ext_need) end_of_length(got, w);
      end
      PH_MASK: begin
        hdr_cnt = hdr_cnt + 4'd1;
        if (hdr_cnt >= MASK_BYTES) end_of_header(got, w);
      end
      PH_DATA: begin
        remaining = remaining - 1'b1;
        if (remaining == '0) ph = PH_B0;
        emit_word(b, remaining == '0, 1'b0, got, w);
      end
      default: ph = PH_B0;
    endcase
  endtask

  task automatic push_byte(input logic [7:0] b, input logic typed, input word_t want);
    logic  got;
    word_t w;
    while ($urandom_range(0, 99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    stream_byte <= b;
    do @(posedge clk); while (!in_ready);
    deframe_byte(b, got, w);
    if (typed) expected_words.push_back(want);
    else if (got) expected_words.push_back(w);
    bytes_sent++;
  endtask

  task automatic send_frame();
    logic [7:0]  frame[$];
    logic [63:0] len64;
    logic [6:0]  code;
    logic [3:0]  op;
    logic        msk;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 30) op = OP_TEXT;
    else if (roll < 50) op = OP_CONT;
    else if (roll < 65) op = OP_CLOSE;
    else op = 4'($urandom_range(0, 15));
    frame.push_back({4'($urandom_range(0, 15)), op});
    msk = 1'($urandom_range(0, 1));
    roll = $urandom_range(0, 99);
    if (roll < 10) begin
      len64 = 0;
      code = 7'd0;
    end else if (roll < 75) begin
      len64 = $urandom_range(1, 12);
      code = 7'(len64);
    end else if (roll < 85) begin
      len64 = $urandom_range(13, 125);
      code = 7'(len64);
    end else if (roll < 93) begin
      len64 = ($urandom_range(0, 7) == 0) ? $urandom_range(256, 400) : $urandom_range(0, 16);
      code = LEN_CODE_16;
    end else begin
      len64 = $urandom_range(0, 16);
      code = LEN_CODE_64;
    end
    frame.push_back({msk, code});
    if (code == LEN_CODE_16) begin
      frame.push_back(len64[15:8]);
      frame.push_back(len64[7:0]);
    end else if (code == LEN_CODE_64) begin
      for (int i = 7; i >= 0; i--) frame.push_back(len64[8*i +: 8]);
    end
    if (msk) repeat (4) frame.push_back(8'($urandom_range(0, 255)));
    repeat (int'(len64)) frame.push_back(8'($urandom_range(0, 255)));
    foreach (frame[i]) push_byte(frame[i], 1'b0, '0);
  endtask

  always @(posedge clk) begin
    word_t exp_w;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end else begin
      if (rst_n && out_valid && out_ready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word: payload_byte %0h", payload_byte);
          err_count++;
        end else begin
          exp_w = expected_words.pop_front();
          if (payload_byte !== exp_w.payload) begin
            $error("payload_byte: expected %0h, got %0h", exp_w.payload, payload_byte);
            err_count++;
          end
          if (frame_kind !== exp_w.kind) begin
            $error("frame_kind: expected %0d, got %0d", exp_w.kind, frame_kind);
            err_count++;
          end
          if (first_of_frame !== exp_w.first) begin
            $error("first_of_frame: expected %0b, got %0b", exp_w.first, first_of_frame);
            err_count++;
          end
          if (last_of_frame !== exp_w.last) begin
            $error("last_of_frame: expected %0b, got %0b", exp_w.last, last_of_frame);
            err_count++;
          end
          if (empty_frame !== exp_w.empty) begin
            $error("empty_frame: expected %0b, got %0b", exp_w.empty, empty_frame);
            err_count++;
          end
        end
      end
      out_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
    end
  end

  initial begin
    int unsigned src_mix [4];
    int unsigned sink_mix [4];
    int unsigned phase_start;
    src_mix = '{0, 60, 0, 33};
    sink_mix = '{0, 0, 60, 33};
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (dir_rows[i]) push_byte(dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
    for (int p = 0; p < 4; p++) begin
      src_idle_pct = src_mix[p];
      sink_stall_pct = sink_mix[p];
      phase_start = bytes_sent;
      while (bytes_sent - phase_start < PHASE_BYTES) send_frame();
    end
    in_valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (err_count == 0 && expected_words.size() == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

endmodule
